// ===== hw/rtl/memory_map_waitstate_decoder_defines.svh =====
// Assertion macros for the memory map and wait-state decoder.
`ifndef MEMORY_MAP_WAITSTATE_DECODER_DEFINES_SVH
`define MEMORY_MAP_WAITSTATE_DECODER_DEFINES_SVH

// Property checked at every edge outside reset.
`define MMWD_CHECK(name, prop, msg) \
   name: assert property (@(posedge clock) disable iff (reset) prop) else $error(msg);

// Property checked at every edge, reset included.
`define MMWD_CHECK_ALWAYS(name, prop, msg) \
   name: assert property (@(posedge clock) prop) else $error(msg);

`endif

// ===== hw/rtl/mmwd_pkg.sv =====
// Package with types, codes and wait tables of the memory map decoder.
`default_nettype none

package mmwd_pkg;

   // Target store codes.
   typedef enum logic [3:0] {
      TGT_UNMAPPED = 4'd0,
      TGT_BIOS     = 4'd1,
      TGT_OPENBUS  = 4'd2,
      TGT_EWRAM    = 4'd3,
      TGT_IWRAM    = 4'd4,
      TGT_MMIO     = 4'd5,
      TGT_PALETTE  = 4'd6,
      TGT_VIDEO    = 4'd7,
      TGT_OAM      = 4'd8,
      TGT_ROM      = 4'd9,
      TGT_BACKUP   = 4'd10
   } target_type;

   // Configuration register indexes.
   typedef enum logic [2:0] {
      REG_ROM0_FIRST  = 3'd0,
      REG_ROM0_SECOND = 3'd1,
      REG_ROM1_FIRST  = 3'd2,
      REG_ROM1_SECOND = 3'd3,
      REG_ROM2_FIRST  = 3'd4,
      REG_ROM2_SECOND = 3'd5,
      REG_BACKUP      = 3'd6,
      REG_INTERNAL    = 3'd7
   } reg_index_type;

   // Cycle kind codes.
   localparam logic [1:0] KIND_NONSEQ = 2'd0;
   localparam logic [1:0] KIND_SEQ    = 2'd1;

   localparam int unsigned OffsetWidth = 25;
   localparam int unsigned WaitWidth   = 5;
   localparam int unsigned CsrAddrWidth = 5;
   localparam int unsigned CsrDataWidth = 32;

   localparam logic [3:0] InternalWaitReset = 4'd1;
   localparam logic [OffsetWidth-1:0] BiosLimit   = 25'h0004000;
   localparam logic [16:0]            VideoMirror = 17'h18000;

   // Wait-state control fields as seen by the wait calculator.
   typedef struct packed {
      logic [1:0] rom0_first;
      logic       rom0_second;
      logic [1:0] rom1_first;
      logic       rom1_second;
      logic [1:0] rom2_first;
      logic       rom2_second;
      logic [1:0] backup;
      logic [3:0] internal;
   } waitcnt_type;

   // Wait-state fields after reset: all zero but the internal wait.
   localparam waitcnt_type WaitcntReset = '{
      rom0_first:  2'd0,
      rom0_second: 1'b0,
      rom1_first:  2'd0,
      rom1_second: 1'b0,
      rom2_first:  2'd0,
      rom2_second: 1'b0,
      backup:      2'd0,
      internal:    InternalWaitReset
   };

   // First-access wait table 4, 3, 2, 8.
   function automatic logic [3:0] first_wait(input logic [1:0] sel);
      logic [3:0] w;
      unique case (sel)
         2'd0:    w = 4'd4;
         2'd1:    w = 4'd3;
         2'd2:    w = 4'd2;
         default: w = 4'd8;
      endcase
      return w;
   endfunction

   // Sequential wait tables of the three ROM windows.
   function automatic logic [3:0] second_wait0(input logic sel);
      return sel ? 4'd1 : 4'd2;
   endfunction

   function automatic logic [3:0] second_wait1(input logic sel);
      return sel ? 4'd1 : 4'd4;
   endfunction

   function automatic logic [3:0] second_wait2(input logic sel);
      return sel ? 4'd1 : 4'd8;
   endfunction

endpackage

`default_nettype wire

// ===== hw/rtl/mmwd_csr.sv =====
// Register file for the wait-state control fields, written over the APB-style port.
`default_nettype none

module mmwd_csr (
   input  wire logic                               clock,
   input  wire logic                               reset,
   input  wire logic                               csr_psel,
   input  wire logic                               csr_penable,
   input  wire logic                               csr_pwrite,
   input  wire logic [mmwd_pkg::CsrAddrWidth-1:0]  csr_paddr,
   input  wire logic [mmwd_pkg::CsrDataWidth-1:0]  csr_pwdata,
   output logic [mmwd_pkg::CsrDataWidth-1:0]       csr_prdata,
   output logic                                    csr_pready,
   output mmwd_pkg::waitcnt_type                   waitcnt
);
   import mmwd_pkg::*;

   waitcnt_type   waitcnt_ff;
   waitcnt_type   waitcnt_in;
   reg_index_type index;
   logic          wr_en;

   assign csr_pready = 1'b1;
   assign index      = reg_index_type'(csr_paddr[CsrAddrWidth-1:2]);
   assign wr_en      = csr_psel & csr_penable & csr_pwrite & csr_pready;

   // Each register takes only the low bits of the write data it holds.
   always_comb begin
      waitcnt_in = waitcnt_ff;
      if (wr_en) begin
         unique case (index)
            REG_ROM0_FIRST:  waitcnt_in.rom0_first  = csr_pwdata[1:0];
            REG_ROM0_SECOND: waitcnt_in.rom0_second = csr_pwdata[0];
            REG_ROM1_FIRST:  waitcnt_in.rom1_first  = csr_pwdata[1:0];
            REG_ROM1_SECOND: waitcnt_in.rom1_second = csr_pwdata[0];
            REG_ROM2_FIRST:  waitcnt_in.rom2_first  = csr_pwdata[1:0];
            REG_ROM2_SECOND: waitcnt_in.rom2_second = csr_pwdata[0];
            REG_BACKUP:      waitcnt_in.backup      = csr_pwdata[1:0];
            REG_INTERNAL:    waitcnt_in.internal    = csr_pwdata[3:0];
            default:         waitcnt_in = waitcnt_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         waitcnt_ff <= WaitcntReset;
      end else begin
         waitcnt_ff <= waitcnt_in;
      end
   end

   // Read data is the addressed register, zero extended.
   always_comb begin
      csr_prdata = '0;
      unique case (index)
         REG_ROM0_FIRST:  csr_prdata[1:0] = waitcnt_ff.rom0_first;
         REG_ROM0_SECOND: csr_prdata[0]   = waitcnt_ff.rom0_second;
         REG_ROM1_FIRST:  csr_prdata[1:0] = waitcnt_ff.rom1_first;
         REG_ROM1_SECOND: csr_prdata[0]   = waitcnt_ff.rom1_second;
         REG_ROM2_FIRST:  csr_prdata[1:0] = waitcnt_ff.rom2_first;
         REG_ROM2_SECOND: csr_prdata[0]   = waitcnt_ff.rom2_second;
         REG_BACKUP:      csr_prdata[1:0] = waitcnt_ff.backup;
         REG_INTERNAL:    csr_prdata[3:0] = waitcnt_ff.internal;
         default:         csr_prdata = '0;
      endcase
   end

   assign waitcnt = waitcnt_ff;

endmodule

`default_nettype wire

// ===== hw/rtl/mmwd_decode.sv =====
// Address decoder: alignment, target region, offset mask and store enable.
`default_nettype none

module mmwd_decode (
   input  wire logic [31:0]                       address,
   input  wire logic [1:0]                        access_size,
   input  wire logic                              is_write,
   output logic [7:0]                             region,
   output mmwd_pkg::target_type                   target,
   output logic [mmwd_pkg::OffsetWidth-1:0]       offset,
   output logic                                   store_enabled
);
   import mmwd_pkg::*;

   logic [31:0] aligned;
   logic [16:0] video_off;

   // Words clear the two low bits, halfwords the lowest; size three acts as a word.
   always_comb begin
      aligned = address;
      if (access_size[1]) begin
         aligned[1:0] = 2'b00;
      end else if (access_size[0]) begin
         aligned[0] = 1'b0;
      end
   end

   assign region = aligned[31:24];

   // The upper 32 KiB of the video window mirrors its first 32 KiB.
   always_comb begin
      video_off = aligned[16:0];
      if (video_off >= VideoMirror) begin
         video_off = {2'b00, aligned[14:0]};
      end
   end

   always_comb begin
      target        = TGT_UNMAPPED;
      offset        = '0;
      store_enabled = 1'b0;
      unique case (region)
         8'h00: begin
            // BIOS accesses past its end go to open bus.
            if (aligned >= 32'(BiosLimit)) begin
               target = TGT_OPENBUS;
            end else begin
               target        = TGT_BIOS;
               offset        = {11'd0, aligned[13:0]};
               store_enabled = ~is_write;
            end
         end
         8'h02: begin
            target        = TGT_EWRAM;
            offset        = {11'd0, aligned[13:0]};
            store_enabled = 1'b1;
         end
         8'h03: begin
            target        = TGT_IWRAM;
            offset        = {10'd0, aligned[14:0]};
            store_enabled = 1'b1;
         end
         8'h04: begin
            target        = TGT_MMIO;
            offset        = {1'b0, aligned[23:0]};
            store_enabled = 1'b1;
         end
         8'h05: begin
            target        = TGT_PALETTE;
            offset        = {15'd0, aligned[9:0]};
            store_enabled = 1'b1;
         end
         8'h06: begin
            target        = TGT_VIDEO;
            offset        = {8'd0, video_off};
            store_enabled = 1'b1;
         end
         8'h07: begin
            target        = TGT_OAM;
            offset        = {15'd0, aligned[9:0]};
            store_enabled = 1'b1;
         end
         8'h08, 8'h09, 8'h0A, 8'h0B, 8'h0C, 8'h0D: begin
            target        = TGT_ROM;
            offset        = aligned[24:0];
            store_enabled = ~is_write;
         end
         8'h0E, 8'h0F: begin
            // The upper backup region is decoded like the lower one.
            target        = TGT_BACKUP;
            offset        = aligned[24:0];
            store_enabled = ~is_write;
         end
         default: begin
            target        = TGT_UNMAPPED;
            offset        = '0;
            store_enabled = 1'b0;
         end
      endcase
   end

endmodule

`default_nettype wire

// ===== hw/rtl/mmwd_wait.sv =====
// Wait-cycle calculator for cartridge windows and internal regions.
`default_nettype none

module mmwd_wait (
   input  wire logic [7:0]                       region,
   input  wire logic                             word,
   input  wire logic                             seq,
   input  wire logic                             fast,
   input  mmwd_pkg::waitcnt_type                 waitcnt,
   output logic [mmwd_pkg::WaitWidth-1:0]        wait_cycles
);
   import mmwd_pkg::*;

   logic                 cart;
   logic [1:0]           window;
   logic [3:0]           first_val;
   logic [3:0]           second_val;
   logic [WaitWidth-1:0] half_ns;
   logic [WaitWidth-1:0] half_s;
   logic [WaitWidth-1:0] cart_cost;
   logic [WaitWidth-1:0] internal_cost;

   assign cart   = (region[7:3] == 5'b00001);
   assign window = region[2:1];

   // Pick the table entries of the addressed window; backup uses one value for both.
   always_comb begin
      unique case (window)
         2'd0: begin
            first_val  = first_wait(waitcnt.rom0_first);
            second_val = second_wait0(waitcnt.rom0_second);
         end
         2'd1: begin
            first_val  = first_wait(waitcnt.rom1_first);
            second_val = second_wait1(waitcnt.rom1_second);
         end
         2'd2: begin
            first_val  = first_wait(waitcnt.rom2_first);
            second_val = second_wait2(waitcnt.rom2_second);
         end
         default: begin
            first_val  = first_wait(waitcnt.backup);
            second_val = first_wait(waitcnt.backup);
         end
      endcase
   end

   assign half_ns = WaitWidth'(first_val) + WaitWidth'(1);
   assign half_s  = WaitWidth'(second_val) + WaitWidth'(1);

   // A word is two halfwords: first plus sequential, or two sequential.
   always_comb begin
      if (!word) begin
         cart_cost = seq ? half_s : half_ns;
      end else if (seq) begin
         cart_cost = {half_s[WaitWidth-2:0], 1'b0};
      end else begin
         cart_cost = half_ns + half_s;
      end
   end

   assign internal_cost = word ? {waitcnt.internal, 1'b0} : {1'b0, waitcnt.internal};

   always_comb begin
      priority if (fast) begin
         wait_cycles = '0;
      end else if (cart) begin
         wait_cycles = cart_cost;
      end else begin
         wait_cycles = internal_cost;
      end
   end

endmodule

`default_nettype wire

// ===== hw/rtl/memory_map_waitstate_decoder.sv =====
// Top level of the memory map and wait-state decoder.
`default_nettype none
`include "memory_map_waitstate_decoder_defines.svh"

// Decodes one CPU bus access per clock, while responses are taken, into a
// target store, a masked and aligned offset, a store enable and a wait-cycle
// charge. An access beat is taken into an input register, decoded and costed
// by shallow logic, and the result is held in an output register, so the
// block sustains one beat per cycle while responses are taken. While a
// response is stalled, one more request can still enter the input register;
// after that the request channel is held off until the response is taken.
// A command beat (command set) only overwrites the stored previous cycle kind
// and gives no response. The previous cycle kind is read and updated as each
// request is accepted, so request order alone defines the
// sequential/non-sequential charge. The user must write wait-state registers
// through the APB-style port while the block is idle; it is not enforced.
module memory_map_waitstate_decoder (
   input  wire logic                               clock,
   input  wire logic                               reset,
   // Request channel.
   input  wire logic                               req_valid,
   output logic                                    req_ready,
   input  wire logic                               req_command,
   input  wire logic [31:0]                        req_address,
   input  wire logic [1:0]                         req_access_size,
   input  wire logic                               req_is_write,
   input  wire logic [1:0]                         req_cycle_kind,
   input  wire logic [1:0]                         req_new_previous_kind,
   // Response channel.
   output logic                                    rsp_valid,
   input  wire logic                               rsp_ready,
   output logic [3:0]                              rsp_target,
   output logic [mmwd_pkg::OffsetWidth-1:0]        rsp_offset,
   output logic                                    rsp_store_enabled,
   output logic [mmwd_pkg::WaitWidth-1:0]          rsp_wait_cycles,
   // Configuration port.
   input  wire logic                               csr_psel,
   input  wire logic                               csr_penable,
   input  wire logic                               csr_pwrite,
   input  wire logic [mmwd_pkg::CsrAddrWidth-1:0]  csr_paddr,
   input  wire logic [mmwd_pkg::CsrDataWidth-1:0]  csr_pwdata,
   output logic [mmwd_pkg::CsrDataWidth-1:0]       csr_prdata,
   output logic                                    csr_pready
);
   import mmwd_pkg::*;

   waitcnt_type          waitcnt;

   // Previous cycle kind.
   logic [1:0]           prev_kind_ff;
   logic [1:0]           prev_kind_in;

   // Input register stage.
   logic                 in_valid_ff;
   logic                 in_valid_in;
   logic [31:0]          in_address_ff;
   logic [1:0]           in_size_ff;
   logic                 in_write_ff;
   logic                 in_fast_ff;
   logic                 in_seq_ff;

   // Output register stage.
   logic                 out_valid_ff;
   logic                 out_valid_in;
   logic [3:0]           out_target_ff;
   logic [OffsetWidth-1:0] out_offset_ff;
   logic                 out_enabled_ff;
   logic [WaitWidth-1:0] out_wait_ff;

   logic                 req_fire;
   logic                 access_fire;
   logic                 out_load;
   logic                 advance;
   logic                 req_seq;

   logic [7:0]           dec_region;
   target_type           dec_target;
   logic [OffsetWidth-1:0] dec_offset;
   logic                 dec_enabled;
   logic [WaitWidth-1:0] dec_wait;

   mmwd_csr u_csr (
      .clock       (clock),
      .reset       (reset),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready),
      .waitcnt     (waitcnt)
   );

   // Handshake: the output register loads when empty or being drained.
   assign out_load    = ~out_valid_ff | rsp_ready;
   assign advance     = in_valid_ff & out_load;
   assign req_ready   = ~in_valid_ff | out_load;
   assign req_fire    = req_valid & req_ready;
   assign access_fire = req_fire & ~req_command;

   // A stored non-sequential kind forces the non-sequential charge.
   assign req_seq = (req_cycle_kind == KIND_SEQ) & (prev_kind_ff != KIND_NONSEQ);

   // Previous kind: commands store it, costed accesses leave it sequential.
   always_comb begin
      prev_kind_in = prev_kind_ff;
      if (req_fire) begin
         if (req_command) begin
            prev_kind_in = req_new_previous_kind;
         end else if (!req_cycle_kind[1]) begin
            prev_kind_in = KIND_SEQ;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         prev_kind_ff <= KIND_NONSEQ;
      end else begin
         prev_kind_ff <= prev_kind_in;
      end
   end

   // Input register stage.
   always_comb begin
      in_valid_in = in_valid_ff;
      if (req_ready) begin
         in_valid_in = access_fire;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else begin
         in_valid_ff <= in_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (access_fire) begin
         in_address_ff <= req_address;
         in_size_ff    <= req_access_size;
         in_write_ff   <= req_is_write;
         in_fast_ff    <= req_cycle_kind[1];
         in_seq_ff     <= req_seq;
      end
   end

   mmwd_decode u_decode (
      .address       (in_address_ff),
      .access_size   (in_size_ff),
      .is_write      (in_write_ff),
      .region        (dec_region),
      .target        (dec_target),
      .offset        (dec_offset),
      .store_enabled (dec_enabled)
   );

   mmwd_wait u_wait (
      .region      (dec_region),
      .word        (in_size_ff[1]),
      .seq         (in_seq_ff),
      .fast        (in_fast_ff),
      .waitcnt     (waitcnt),
      .wait_cycles (dec_wait)
   );

   // Output register stage.
   always_comb begin
      out_valid_in = out_valid_ff;
      if (out_load) begin
         out_valid_in = in_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else begin
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         out_target_ff  <= dec_target;
         out_offset_ff  <= dec_offset;
         out_enabled_ff <= dec_enabled;
         out_wait_ff    <= dec_wait;
      end
   end

   assign rsp_valid         = out_valid_ff;
   assign rsp_target        = out_target_ff;
   assign rsp_offset        = out_offset_ff;
   assign rsp_store_enabled = out_enabled_ff;
   assign rsp_wait_cycles   = out_wait_ff;

   // Checks on the pipeline and the decode.
   `MMWD_CHECK_ALWAYS(a_reset_empty, reset |=> !rsp_valid && !in_valid_ff, "pipeline not empty after reset")
   `MMWD_CHECK(a_command_stores, req_fire && req_command |=> prev_kind_ff == $past(req_new_previous_kind), "command beat did not store previous kind")
   `MMWD_CHECK(a_costed_seq, access_fire && !req_cycle_kind[1] |=> prev_kind_ff == KIND_SEQ, "costed access did not leave sequential state")
   `MMWD_CHECK(a_unmapped_quiet, rsp_valid && rsp_target == TGT_UNMAPPED |-> !rsp_store_enabled && rsp_offset == '0, "unmapped access reached a store")

endmodule

`default_nettype wire

// ===== tb/tb_memory_map_waitstate_decoder.sv =====
// Testbench for the memory map and wait-state decoder: predicts and checks every response.
`timescale 1ns / 100ps

module tb_memory_map_waitstate_decoder;
   import mmwd_pkg::*;

   // Field codes that the package does not name.
   localparam logic [1:0] KIND_FAST  = 2'd2;
   localparam logic [1:0] KIND_FAST3 = 2'd3;
   localparam logic [1:0] SIZE_BYTE  = 2'd0;
   localparam logic [1:0] SIZE_HALF  = 2'd1;
   localparam logic [1:0] SIZE_WORD  = 2'd2;
   localparam logic [1:0] SIZE_WIDE  = 2'd3;

   // Address regions, taken from bits 31..24.
   localparam logic [7:0] REGION_BIOS    = 8'h00;
   localparam logic [7:0] REGION_EWRAM   = 8'h02;
   localparam logic [7:0] REGION_IWRAM   = 8'h03;
   localparam logic [7:0] REGION_MMIO    = 8'h04;
   localparam logic [7:0] REGION_PALETTE = 8'h05;
   localparam logic [7:0] REGION_VIDEO   = 8'h06;
   localparam logic [7:0] REGION_OAM     = 8'h07;

   localparam int unsigned SETTINGS_RUN   = 7;
   localparam int unsigned BEATS_PER_RUN  = 200;
   localparam int unsigned LONG_HOLD      = 80;
   localparam int unsigned SETTLE_CYCLES  = 4;
   localparam int unsigned CYCLE_LIMIT    = 200000;

   // One request beat as offered on the request channel.
   typedef struct packed {
      logic        command;
      logic [31:0] address;
      logic [1:0]  size;
      logic        is_write;
      logic [1:0]  kind;
      logic [1:0]  new_prev;
   } access_beat_type;

   // One decoded response beat.
   typedef struct packed {
      target_type  target;
      logic [24:0] offset;
      logic        store_enabled;
      logic [4:0]  wait_cycles;
   } decode_result_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_ready;
   logic        req_command = 1'b0;
   logic [31:0] req_address = '0;
   logic [1:0]  req_access_size = '0;
   logic        req_is_write = 1'b0;
   logic [1:0]  req_cycle_kind = '0;
   logic [1:0]  req_new_previous_kind = '0;
   logic        rsp_valid;
   logic        rsp_ready = 1'b0;
   logic [3:0]  rsp_target;
   logic [OffsetWidth-1:0] rsp_offset;
   logic        rsp_store_enabled;
   logic [WaitWidth-1:0]   rsp_wait_cycles;
   logic        csr_psel = 1'b0;
   logic        csr_penable = 1'b0;
   logic        csr_pwrite = 1'b0;
   logic [CsrAddrWidth-1:0] csr_paddr = '0;
   logic [CsrDataWidth-1:0] csr_pwdata = '0;
   logic [CsrDataWidth-1:0] csr_prdata;
   logic        csr_pready;

   // Predictor state: wait-state settings and the stored previous cycle kind.
   waitcnt_type wait_cfg;
   logic [1:0]  last_kind;

   access_beat_type   pending_accesses[$];
   decode_result_type expected_decodes[$];

   logic        req_taken = 1'b0;
   logic        steady_flow = 1'b0;
   int unsigned holds_requested = 0;
   int unsigned holds_seen = 0;
   int unsigned hold_left = 0;
   int unsigned mismatches = 0;
   int unsigned access_count = 0;
   int unsigned command_count = 0;
   int unsigned cycle_count = 0;

   memory_map_waitstate_decoder DUT (
      .clock                 (clock),
      .reset                 (reset),
      .req_valid             (req_valid),
      .req_ready             (req_ready),
      .req_command           (req_command),
      .req_address           (req_address),
      .req_access_size       (req_access_size),
      .req_is_write          (req_is_write),
      .req_cycle_kind        (req_cycle_kind),
      .req_new_previous_kind (req_new_previous_kind),
      .rsp_valid             (rsp_valid),
      .rsp_ready             (rsp_ready),
      .rsp_target            (rsp_target),
      .rsp_offset            (rsp_offset),
      .rsp_store_enabled     (rsp_store_enabled),
      .rsp_wait_cycles       (rsp_wait_cycles),
      .csr_psel              (csr_psel),
      .csr_penable           (csr_penable),
      .csr_pwrite            (csr_pwrite),
      .csr_paddr             (csr_paddr),
      .csr_pwdata            (csr_pwdata),
      .csr_prdata            (csr_prdata),
      .csr_pready            (csr_pready)
   );

   always #2 clock = ~clock;

   // First-access wait selected by a two-bit field.
   function automatic logic [3:0] first_access_wait(input logic [1:0] sel);
      case (sel)
         2'd0:    return 4'd4;
         2'd1:    return 4'd3;
         2'd2:    return 4'd2;
         default: return 4'd8;
      endcase
   endfunction

   // Halfword cost of a cartridge window; window 3 is the backup RAM.
   function automatic logic [4:0] cart_halfword_wait(input logic [1:0] window, input logic seq);
      logic [3:0] w;
      if (window == 2'd3) begin
         w = first_access_wait(wait_cfg.backup);
      end else if (!seq) begin
         case (window)
            2'd0:    w = first_access_wait(wait_cfg.rom0_first);
            2'd1:    w = first_access_wait(wait_cfg.rom1_first);
            default: w = first_access_wait(wait_cfg.rom2_first);
         endcase
      end else begin
         case (window)
            2'd0:    w = wait_cfg.rom0_second ? 4'd1 : 4'd2;
            2'd1:    w = wait_cfg.rom1_second ? 4'd1 : 4'd4;
            default: w = wait_cfg.rom2_second ? 4'd1 : 4'd8;
         endcase
      end
      return 5'd1 + {1'b0, w};
   endfunction

   // Wait cycles charged for one costed access, indexed by the unmasked region.
   function automatic logic [4:0] access_wait(input logic [7:0] region, input logic word,
                                              input logic seq);
      logic [4:0] first_half;
      logic [4:0] seq_half;
      if (region[7:3] == 5'b00001) begin
         first_half = cart_halfword_wait(region[2:1], seq);
         seq_half = cart_halfword_wait(region[2:1], 1'b1);
         if (!word) return first_half;
         if (seq) return {seq_half[3:0], 1'b0};
         return first_half + seq_half;
      end
      return word ? {wait_cfg.internal, 1'b0} : {1'b0, wait_cfg.internal};
   endfunction

   // Decodes one access beat and, for costed beats, advances the stored cycle kind.
   function automatic decode_result_type decode_access(input access_beat_type beat);
      decode_result_type res;
      logic [31:0] addr;
      logic [7:0]  region;
      logic        word;
      logic        seq;
      addr = beat.address;
      word = beat.size[1];
      if (word) addr[1:0] = 2'b00;
      else if (beat.size == SIZE_HALF) addr[0] = 1'b0;
      region = addr[31:24];
      res.target = TGT_UNMAPPED;
      res.offset = '0;
      res.store_enabled = 1'b0;
      res.wait_cycles = '0;
      case (region)
         REGION_BIOS: begin
            if (addr >= 32'h4000) begin
               res.target = TGT_OPENBUS;
            end else begin
               res.target = TGT_BIOS;
               res.offset = addr[24:0];
               res.store_enabled = !beat.is_write;
            end
         end
         REGION_EWRAM: begin
            res.target = TGT_EWRAM;
            res.offset = addr[24:0] & 25'h3FFF;
            res.store_enabled = 1'b1;
         end
         REGION_IWRAM: begin
            res.target = TGT_IWRAM;
            res.offset = addr[24:0] & 25'h7FFF;
            res.store_enabled = 1'b1;
         end
         REGION_MMIO: begin
            res.target = TGT_MMIO;
            res.offset = addr[24:0] & 25'hFFFFFF;
            res.store_enabled = 1'b1;
         end
         REGION_PALETTE: begin
            res.target = TGT_PALETTE;
            res.offset = addr[24:0] & 25'h3FF;
            res.store_enabled = 1'b1;
         end
         REGION_VIDEO: begin
            // The top 32 KiB of the 128 KiB window mirror its bottom.
            res.target = TGT_VIDEO;
            res.offset = addr[24:0] & 25'h1FFFF;
            if (res.offset >= 25'h18000) res.offset = res.offset & 25'h7FFF;
            res.store_enabled = 1'b1;
         end
         REGION_OAM: begin
            res.target = TGT_OAM;
            res.offset = addr[24:0] & 25'h3FF;
            res.store_enabled = 1'b1;
         end
         8'h08, 8'h09, 8'h0A, 8'h0B, 8'h0C, 8'h0D: begin
            res.target = TGT_ROM;
            res.offset = addr[24:0];
            res.store_enabled = !beat.is_write;
         end
         8'h0E, 8'h0F: begin
            res.target = TGT_BACKUP;
            res.offset = addr[24:0];
            res.store_enabled = !beat.is_write;
         end
         default: ;
      endcase
      // Fast cycles cost nothing and leave the stored kind alone.
      if (!beat.kind[1]) begin
         seq = (beat.kind == KIND_SEQ) && (last_kind != KIND_NONSEQ);
         res.wait_cycles = access_wait(region, word, seq);
         last_kind = KIND_SEQ;
      end
      return res;
   endfunction

   // Random access beat, with a few stored-kind commands mixed in.
   function automatic access_beat_type random_access();
      access_beat_type b;
      int unsigned  pick;
      logic [7:0]   region;
      b.command = ($urandom_range(99) < 6);
      b.new_prev = 2'($urandom_range(3));
      b.address = $urandom;
      pick = $urandom_range(99);
      if (pick < 7) region = 8'($urandom_range(255, 16));
      else region = 8'($urandom_range(15));
      b.address[31:24] = region;
      if (region == REGION_BIOS && $urandom_range(2) != 0) b.address[23:14] = '0;
      if (region == REGION_VIDEO && $urandom_range(1) != 0) b.address[16:15] = 2'b11;
      pick = $urandom_range(9);
      b.size = (pick < 3) ? SIZE_BYTE : (pick < 6) ? SIZE_HALF : (pick < 9) ? SIZE_WORD : SIZE_WIDE;
      b.is_write = 1'($urandom_range(1));
      pick = $urandom_range(9);
      b.kind = (pick < 3) ? KIND_NONSEQ : (pick < 7) ? KIND_SEQ : (pick < 9) ? KIND_FAST : KIND_FAST3;
      return b;
   endfunction

   task automatic push_access(input logic [31:0] addr, input logic [1:0] size,
                              input logic wr, input logic [1:0] kind);
      access_beat_type b;
      b.command = 1'b0;
      b.address = addr;
      b.size = size;
      b.is_write = wr;
      b.kind = kind;
      b.new_prev = 2'($urandom_range(3));
      pending_accesses.push_back(b);
   endtask

   task automatic push_store_kind(input logic [1:0] kind);
      access_beat_type b;
      b = random_access();
      b.command = 1'b1;
      b.new_prev = kind;
      pending_accesses.push_back(b);
   endtask

   // A non-sequential access followed by a run of sequential ones.
   task automatic queue_burst(output int unsigned pushed);
      access_beat_type b;
      int unsigned  len;
      int unsigned  step;
      b = random_access();
      b.command = 1'b0;
      b.kind = KIND_NONSEQ;
      step = b.size[1] ? 4 : b.size[0] ? 2 : 1;
      len = $urandom_range(6, 2);
      pending_accesses.push_back(b);
      for (int unsigned i = 0; i < len; i++) begin
         b.address = b.address + step;
         b.kind = KIND_SEQ;
         pending_accesses.push_back(b);
      end
      pushed = len + 1;
   endtask

   task automatic check_field(input string field, input logic [31:0] want, input logic [31:0] got);
      if (want !== got) begin
         $display("%0t: %s mismatch, expected 0x%0h, actual 0x%0h", $time, field, want, got);
         mismatches++;
      end
   endtask

   // Writes one wait-state register, reads it back and updates the predictor.
   task automatic program_wait_reg(input reg_index_type idx, input logic [3:0] value);
      logic [3:0] field;
      case (idx)
         REG_ROM0_SECOND, REG_ROM1_SECOND, REG_ROM2_SECOND: field = value & 4'h1;
         REG_INTERNAL: field = value;
         default: field = value & 4'h3;
      endcase
      @(negedge clock);
      csr_psel <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite <= 1'b1;
      csr_paddr <= {idx, 2'b00};
      csr_pwdata <= {28'b0, field};
      @(negedge clock);
      csr_penable <= 1'b1;
      do @(posedge clock); while (!csr_pready);
      case (idx)
         REG_ROM0_FIRST:  wait_cfg.rom0_first = field[1:0];
         REG_ROM0_SECOND: wait_cfg.rom0_second = field[0];
         REG_ROM1_FIRST:  wait_cfg.rom1_first = field[1:0];
         REG_ROM1_SECOND: wait_cfg.rom1_second = field[0];
         REG_ROM2_FIRST:  wait_cfg.rom2_first = field[1:0];
         REG_ROM2_SECOND: wait_cfg.rom2_second = field[0];
         REG_BACKUP:      wait_cfg.backup = field[1:0];
         default:         wait_cfg.internal = field;
      endcase
      @(negedge clock);
      csr_psel <= 1'b0;
      csr_penable <= 1'b0;
      @(negedge clock);
      csr_psel <= 1'b1;
      csr_pwrite <= 1'b0;
      @(negedge clock);
      csr_penable <= 1'b1;
      do @(posedge clock); while (!csr_pready);
      check_field("register readback", {28'b0, field}, csr_prdata);
      @(negedge clock);
      csr_psel <= 1'b0;
      csr_penable <= 1'b0;
   endtask

   // Waits until every queued beat is sent and every response has arrived.
   // The state is looked at on the rising edge, where the driver never acts.
   task automatic wait_for_drain();
      while (pending_accesses.size() != 0 || req_valid || expected_decodes.size() != 0)
         @(posedge clock);
      repeat (SETTLE_CYCLES) @(negedge clock);
   endtask

   // Request driver: offers queued beats, holding each until it is taken.
   always @(negedge clock) begin : request_driver
      access_beat_type beat;
      if (reset) begin
         req_valid <= 1'b0;
      end else if (!req_valid || req_taken) begin
         if (pending_accesses.size() != 0 && (steady_flow || $urandom_range(99) >= 36)) begin
            beat = pending_accesses.pop_front();
            req_valid <= 1'b1;
            req_command <= beat.command;
            req_address <= beat.address;
            req_access_size <= beat.size;
            req_is_write <= beat.is_write;
            req_cycle_kind <= beat.kind;
            req_new_previous_kind <= beat.new_prev;
         end else begin
            req_valid <= 1'b0;
         end
      end
   end

   // Response pacing, with a long hold-off whenever one is requested.
   always @(negedge clock) begin : response_pacer
      if (hold_left != 0) begin
         hold_left <= hold_left - 1;
         rsp_ready <= 1'b0;
      end else if (holds_seen != holds_requested) begin
         holds_seen <= holds_requested;
         hold_left <= LONG_HOLD - 1;
         rsp_ready <= 1'b0;
      end else begin
         rsp_ready <= steady_flow || ($urandom_range(99) >= 36);
      end
   end

   // Monitor: predicts each accepted request and checks each response beat.
   always @(posedge clock) begin : bus_monitor
      access_beat_type   beat;
      decode_result_type want;
      req_taken <= req_valid && req_ready;
      if (!reset) begin
         if (req_valid && req_ready) begin
            beat.command = req_command;
            beat.address = req_address;
            beat.size = req_access_size;
            beat.is_write = req_is_write;
            beat.kind = req_cycle_kind;
            beat.new_prev = req_new_previous_kind;
            if (beat.command) begin
               last_kind = beat.new_prev;
               command_count++;
            end else begin
               expected_decodes.push_back(decode_access(beat));
               access_count++;
            end
         end
         if (rsp_valid && rsp_ready) begin
            if (expected_decodes.size() == 0) begin
               $display("%0t: unexpected response, expected none, actual target 0x%0h offset 0x%0h",
                        $time, rsp_target, rsp_offset);
               mismatches++;
            end else begin
               want = expected_decodes.pop_front();
               check_field("target", want.target, rsp_target);
               check_field("offset", want.offset, rsp_offset);
               check_field("store_enabled", want.store_enabled, rsp_store_enabled);
               check_field("wait_cycles", want.wait_cycles, rsp_wait_cycles);
            end
         end
      end
   end

   // Watchdog on the whole run.
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("tb_memory_map_waitstate_decoder NOT OK");
         $finish;
      end
   end

   // Stimulus sequencing: reset, then one run of beats per wait-state setting.
   initial begin
      logic [3:0]  cfg_vals [8];
      int unsigned queued;
      int unsigned pushed;
      wait_cfg = '0;
      wait_cfg.internal = InternalWaitReset;
      last_kind = KIND_NONSEQ;
      repeat (9) @(negedge clock);
      reset <= 1'b0;

      for (int unsigned run = 0; run < SETTINGS_RUN; run++) begin
         // Settings: reset values, all maxima, reset again, zero internal wait, random.
         if (run > 0) begin
            for (int unsigned i = 0; i < 8; i++) begin
               case (run)
                  1: cfg_vals[i] = (i == 7) ? 4'd15 : 4'd3;
                  2: cfg_vals[i] = (i == 7) ? 4'd1 : 4'd0;
                  3: cfg_vals[i] = (i == 7) ? 4'd0 : 4'($urandom_range(3));
                  default: cfg_vals[i] = (i == 7) ? 4'($urandom_range(15, 1))
                                                  : 4'($urandom_range(3));
               endcase
               program_wait_reg(reg_index_type'(i), cfg_vals[i]);
            end
         end
         @(posedge clock);

         // Directed beats: region edges, alignment, dropped writes, mirror and kinds.
         if (run == 0) begin
            push_access(32'h0000_0000, SIZE_WORD, 1'b0, KIND_NONSEQ);
            push_access(32'h0000_3FFF, SIZE_BYTE, 1'b0, KIND_SEQ);
            push_access(32'h0000_3FFF, SIZE_HALF, 1'b1, KIND_SEQ);
            push_access(32'h0000_4000, SIZE_WORD, 1'b0, KIND_NONSEQ);
            push_access(32'h0100_1235, SIZE_HALF, 1'b0, KIND_SEQ);
            push_access(32'hFFFF_FFFF, SIZE_WIDE, 1'b1, KIND_SEQ);
            push_access(32'h02FF_FFFF, SIZE_BYTE, 1'b1, KIND_FAST);
            push_access(32'h03FF_FFFD, SIZE_HALF, 1'b0, KIND_SEQ);
            push_access(32'h04FF_FFFF, SIZE_WORD, 1'b1, KIND_FAST3);
            push_access(32'h05FF_FFFF, SIZE_HALF, 1'b0, KIND_NONSEQ);
            push_access(32'h0601_7FFF, SIZE_BYTE, 1'b0, KIND_SEQ);
            push_access(32'h0601_8000, SIZE_WORD, 1'b1, KIND_SEQ);
            push_access(32'h060F_FFFF, SIZE_HALF, 1'b0, KIND_SEQ);
            push_access(32'h07FF_FFFF, SIZE_BYTE, 1'b1, KIND_NONSEQ);
            push_access(32'h0800_0001, SIZE_HALF, 1'b1, KIND_SEQ);
            push_access(32'h09FF_FFFF, SIZE_WORD, 1'b0, KIND_SEQ);
            push_access(32'h0A00_0010, SIZE_BYTE, 1'b0, KIND_NONSEQ);
            push_access(32'h0B12_3457, SIZE_HALF, 1'b0, KIND_SEQ);
            push_store_kind(KIND_NONSEQ);
            push_access(32'h0C00_0000, SIZE_WORD, 1'b0, KIND_SEQ);
            push_store_kind(KIND_FAST);
            push_access(32'h0D00_0002, SIZE_HALF, 1'b0, KIND_SEQ);
            push_store_kind(KIND_FAST3);
            push_access(32'h0E00_1234, SIZE_WORD, 1'b1, KIND_SEQ);
            push_access(32'h0F00_0001, SIZE_BYTE, 1'b0, KIND_NONSEQ);
         end

         // One setting runs without any idling on either side.
         steady_flow = (run == 3);
         queued = 0;
         while (queued < BEATS_PER_RUN) begin
            if ($urandom_range(9) == 0) begin
               queue_burst(pushed);
               queued += pushed;
            end else begin
               pending_accesses.push_back(random_access());
               queued++;
            end
         end
         // Hold responses off long enough for the block to back up its input.
         if (run == 2) holds_requested++;
         wait_for_drain();
         steady_flow = 1'b0;
      end

      $display("Run covered %0d access beats and %0d stored-kind commands over %0d settings,",
               access_count, command_count, SETTINGS_RUN);
      $display("with bursts, a long response hold-off, a no-idle run and zero internal wait.");
      if (mismatches == 0 && expected_decodes.size() == 0) begin
         $display("tb_memory_map_waitstate_decoder OK");
      end else begin
         $display("tb_memory_map_waitstate_decoder NOT OK");
      end
      $finish;
   end

endmodule
